FILE: rtl/core/tcpim_pkg.sv
// Shared constants and types for the TCP out-of-order interval merger.
package tcpim_pkg;
  localparam int unsigned DefMaxIntervals = 16;
  localparam int unsigned SegW = 16;
  localparam int unsigned EndW = 17;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [SegW-1:0] start;
    logic [SegW-1:0] length;
  } seg_t;

  // Saturate a 17-bit length to 16 bits
  function automatic logic [SegW-1:0] sat_len(input logic [EndW-1:0] v);
    sat_len = v[EndW-1] ? {SegW{1'b1}} : v[SegW-1:0];
  endfunction
endpackage

FILE: rtl/core/tcpim_front.sv
// Input stage: accepts segments, rejects nothing, queues them for the table engine.
module tcpim_front import tcpim_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [SegW-1:0] seg_start_i,
  input  logic [SegW-1:0] seg_length_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output seg_t            q_item_o
);
  seg_t       mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'(QueueDepth));
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = mem_q[rp_q];

  // Two-entry queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].start <= seg_start_i;
      mem_q[wp_q].length <= seg_length_i;
    end
  end
endmodule

FILE: rtl/core/tcpim_back.sv
// Table engine: search, insert or extend, then merge following intervals one per cycle.
module tcpim_back import tcpim_pkg::*; #(
  parameter int unsigned MaxIntervals = DefMaxIntervals
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  seg_t            q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [SegW-1:0] merged_start_o,
  output logic [SegW-1:0] merged_length_o,
  output logic [4:0]      interval_count_o,
  output logic            table_full_o,
  output logic [SegW-1:0] head_start_o,
  output logic [SegW-1:0] head_length_o
);
  localparam int unsigned IdxW = $clog2(MaxIntervals);
  localparam int unsigned CntW = $clog2(MaxIntervals + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StMerge  = 2'd2;
  localparam logic [1:0] StOut    = 2'd3;

  logic [SegW-1:0] st_q  [MaxIntervals];
  logic [SegW-1:0] ln_q  [MaxIntervals];
  logic [CntW-1:0] used_q;
  logic [1:0]      state_q;
  logic [CntW-1:0] k_q;
  logic            found_q;
  logic [IdxW-1:0] last_q, cur_q;
  seg_t            seg_q;
  logic            full_q;

  logic [IdxW-1:0] k_idx;
  logic [EndW-1:0] end_last, want, end_cur, end_nxt;
  logic [IdxW-1:0] pos;
  logic [IdxW-1:0] nxt;

  assign k_idx = k_q[IdxW-1:0];
  assign end_last = {1'b0, st_q[last_q]} + {1'b0, ln_q[last_q]};
  assign want = {1'b0, seg_q.start} + {1'b0, seg_q.length} - {1'b0, st_q[last_q]};
  assign pos = found_q ? last_q + IdxW'(1) : '0;
  assign nxt = cur_q + IdxW'(1);
  assign end_cur = {1'b0, st_q[cur_q]} + {1'b0, ln_q[cur_q]};
  assign end_nxt = {1'b0, st_q[nxt]} + {1'b0, ln_q[nxt]};

  assign q_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign merged_start_o = full_q ? '0 : st_q[cur_q];
  assign merged_length_o = full_q ? '0 : ln_q[cur_q];
  assign interval_count_o = 5'(used_q);
  assign table_full_o = full_q;
  assign head_start_o = (used_q != '0) ? st_q[0] : '0;
  assign head_length_o = (used_q != '0) ? ln_q[0] : '0;

  // Control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      used_q <= '0;
      k_q <= '0;
      found_q <= 1'b0;
      last_q <= '0;
      cur_q <= '0;
      full_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: if (q_valid_i) begin
          state_q <= StSearch;
          k_q <= '0;
          found_q <= 1'b0;
          last_q <= '0;
          full_q <= 1'b0;
        end
        StSearch: begin
          if (k_q < used_q && st_q[k_idx] <= seg_q.start) begin
            // One stored interval examined per cycle
            last_q <= k_idx;
            found_q <= 1'b1;
            k_q <= k_q + CntW'(1);
          end else if (found_q && end_last > {1'b0, seg_q.start}) begin
            cur_q <= last_q;
            state_q <= StMerge;
          end else if (used_q >= CntW'(MaxIntervals)) begin
            full_q <= 1'b1;
            state_q <= StOut;
          end else begin
            cur_q <= pos;
            used_q <= used_q + CntW'(1);
            state_q <= StMerge;
          end
        end
        StMerge: begin
          if ({1'b0, cur_q} + CntW'(1) < used_q && end_cur > {1'b0, st_q[nxt]}) begin
            used_q <= used_q - CntW'(1);
          end else begin
            state_q <= StOut;
          end
        end
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  // Table datapath
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i) seg_q <= q_item_i;
    if (state_q == StSearch && !(k_q < used_q && st_q[k_idx] <= seg_q.start)) begin
      if (found_q && end_last > {1'b0, seg_q.start}) begin
        if ({1'b0, ln_q[last_q]} < want) ln_q[last_q] <= sat_len(want);
      end else if (used_q < CntW'(MaxIntervals)) begin
        for (int i = 0; i < MaxIntervals; i++) begin
          if (IdxW'(i) == pos) begin
            st_q[i] <= seg_q.start;
            ln_q[i] <= seg_q.length;
          end else if (i > 0 && IdxW'(i) > pos && CntW'(i) <= used_q) begin
            st_q[i] <= st_q[i-1];
            ln_q[i] <= ln_q[i-1];
          end
        end
      end
    end
    if (state_q == StMerge && {1'b0, cur_q} + CntW'(1) < used_q
        && end_cur > {1'b0, st_q[nxt]}) begin
      if (end_cur < end_nxt) ln_q[cur_q] <= sat_len(end_nxt - {1'b0, st_q[cur_q]});
      for (int i = 0; i < MaxIntervals - 1; i++) begin
        if (IdxW'(i) > cur_q) begin
          st_q[i] <= st_q[i+1];
          ln_q[i] <= ln_q[i+1];
        end
      end
    end
  end
endmodule

FILE: rtl/core/tcp_ooo_interval_merger.sv
// Top level of the TCP out-of-order interval merger.
// Usage: present seg_start_i/seg_length_i with in_valid_i; an item is taken
// when in_ready_o is high. Each segment yields one result on the out channel
// (out_valid_o/out_ready_i): the interval now holding it, the interval count,
// a table-full drop flag and the head interval.
// A two-entry queue lets segments be taken while the table engine works.
// A segment passes through the queue, then a search that examines one stored
// interval per cycle plus a decision cycle, a merge that absorbs one following
// interval per cycle plus a final check, then the result is held until taken.
// The table engine takes a new segment only after the last result is taken;
// later segments wait in the queue.
// Reset empties the table (count zero); entries hold no reset value.
// When the receiver stalls the result holds, the engine waits and the queue
// fills, after which in_ready_o drops.
module tcp_ooo_interval_merger import tcpim_pkg::*; #(
  parameter int unsigned MaxIntervals = DefMaxIntervals
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [SegW-1:0] seg_start_i,
  input  logic [SegW-1:0] seg_length_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [SegW-1:0] merged_start_o,
  output logic [SegW-1:0] merged_length_o,
  output logic [4:0]      interval_count_o,
  output logic            table_full_o,
  output logic [SegW-1:0] head_start_o,
  output logic [SegW-1:0] head_length_o
);
  logic q_valid, q_ready;
  seg_t q_item;

  tcpim_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .seg_start_i, .seg_length_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  tcpim_back #(.MaxIntervals(MaxIntervals)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o, .out_ready_i, .merged_start_o, .merged_length_o,
    .interval_count_o, .table_full_o, .head_start_o, .head_length_o
  );
endmodule
